/* design/fra_pkg.sv */
// Shared types and constants of the fixed region allocator.
// Used by every module of the block; depends on nothing.
package fra_pkg;

    localparam int ADDR_W      = 48;
    localparam int PAGES_W     = 17;
    localparam int COUNT_W     = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int WORD_W      = 16;
    localparam int WORD_SEL_W  = 4;
    localparam int PAGES_MAX   = 65536;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_PAGES = 2'd1,
        CFG_COUNT = 2'd2
    } cfg_index_t;

endpackage

/* design/fixed_region_allocator_unit.sv */
// Fixed region allocator: first-fit allocation and checked release of equal regions.
// Allocate: read and check each busy word in turn, then multiply the index and add the base.
// Free: multiply and range check, then the one-bit-a-cycle divider, then read and clear the busy bit.
// One command at a time; the busy-word memory port and the shared multiplier pace it.
// Reset: synchronous, active low; a clearing pass over every busy word follows,
// during which no command is taken. Depends on fra_pkg, fra_busy_mem, fra_divider.
module fixed_region_allocator_unit #(
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [fra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fra_pkg::ADDR_W-1:0]      cfg_wr_data,
    // command channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [fra_pkg::ADDR_W-1:0]      s_free_address,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [fra_pkg::ADDR_W-1:0]      m_alloc_address
);

    localparam int AW     = fra_pkg::ADDR_W;
    localparam int PW     = fra_pkg::PAGES_W;
    localparam int CW     = fra_pkg::COUNT_W;
    localparam int WW     = fra_pkg::WORD_W;
    localparam int WS     = fra_pkg::WORD_SEL_W;
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int SIZE_W = PW + PB_W;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int Q_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int P_W    = CNT_W + SIZE_W;
    localparam int NW     = (MAX_REGIONS + WW - 1) / WW;
    localparam int WA_W   = (NW > 1) ? $clog2(NW) : 1;
    localparam int IX_W   = Q_W + WS;
    localparam int CMPW   = WA_W + WS + CNT_W;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_ARD    = 12'b0000_0000_0100,
        S_ACHK   = 12'b0000_0000_1000,
        S_AMUL   = 12'b0000_0001_0000,
        S_AADDR  = 12'b0000_0010_0000,
        S_FMUL   = 12'b0000_0100_0000,
        S_FRANGE = 12'b0000_1000_0000,
        S_FDIV   = 12'b0001_0000_0000,
        S_FRD    = 12'b0010_0000_0000,
        S_FWR    = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [AW-1:0]  cfg_base_reg;
    logic [PW-1:0]  cfg_pages_reg;
    logic [CW-1:0]  cfg_count_reg;

    // per-command working registers
    logic                       cmd_reg;
    logic [AW-1:0]              faddr_reg;
    logic [SIZE_W-1:0]          size_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [AW-1:0]              off_reg;
    logic [P_W-1:0]             prod_reg;
    logic [Q_W-1:0]             idx_reg;
    logic [WA_W-1:0]            w_reg;
    fra_pkg::status_t           res_status_reg;
    logic [AW-1:0]              res_addr_reg;

    // output register
    logic                       m_valid_reg;
    logic [1:0]                 m_status_reg;
    logic [AW-1:0]              m_addr_reg;

    // datapath helpers
    logic [PW-1:0]      pages_eff;
    logic [CNT_W-1:0]   cnt_eff;
    logic [SIZE_W-1:0]  size_calc;
    logic [CNT_W-1:0]   mul_a;
    logic [P_W-1:0]     mul_out;
    logic [WW-1:0]      free_bits;
    logic               found;
    logic [WS-1:0]      found_bit;
    logic [CMPW-1:0]    next_start;
    logic               scan_last;
    logic [WA_W-1:0]    idx_word;
    logic [WS-1:0]      idx_bit;
    logic               addr_bad;
    logic               accept;

    // memory and divider hookup
    logic               mem_wr_en;
    logic [WA_W-1:0]    mem_wr_addr;
    logic [WW-1:0]      mem_wr_data;
    logic [WA_W-1:0]    mem_rd_addr;
    logic [WW-1:0]      mem_rd_data;
    logic               div_start;
    logic               div_done;
    logic               div_rem_zero;
    logic [Q_W-1:0]     div_quot;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------
    // Configuration registers: written only while the block is idle; a user rule, not enforced.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_reg  <= '0;
            cfg_pages_reg <= PW'(1);
            cfg_count_reg <= CW'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fra_pkg::CFG_BASE:  cfg_base_reg  <= cfg_wr_data;
                fra_pkg::CFG_PAGES: cfg_pages_reg <= cfg_wr_data[PW-1:0];
                fra_pkg::CFG_COUNT: cfg_count_reg <= cfg_wr_data[CW-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Zero pages act as one, anything above the maximum is clamped.
    always_comb begin
        if (cfg_pages_reg == '0) begin
            pages_eff = PW'(1);
        end else if (32'(cfg_pages_reg) > fra_pkg::PAGES_MAX) begin
            pages_eff = PW'(fra_pkg::PAGES_MAX);
        end else begin
            pages_eff = cfg_pages_reg;
        end
    end

    // Count above the pool size acts as the pool size.
    assign cnt_eff = (32'(cfg_count_reg) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                         : CNT_W'(cfg_count_reg);

    assign size_calc = SIZE_W'(pages_eff) * SIZE_W'(PAGE_BYTES);

    // ---------------------------------------------------------------
    // Shared multiplier: count * size for the range check on free,
    // index * size for the start address on allocate.
    // ---------------------------------------------------------------
    assign mul_a   = (state_reg == S_AMUL) ? CNT_W'(idx_reg) : cnt_reg;
    assign mul_out = P_W'(mul_a) * P_W'(size_reg);

    // ---------------------------------------------------------------
    // First-fit scan of one busy word: only regions below the count
    // qualify; the lowest free bit wins.
    // ---------------------------------------------------------------
    always_comb begin
        for (int b = 0; b < WW; b++) begin
            free_bits[b] = !mem_rd_data[b] &&
                (((CMPW'(w_reg) << WS) | CMPW'(b)) < CMPW'(cnt_reg));
        end
    end

    always_comb begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found     = 1'b1;
                found_bit = WS'(b);
            end
        end
    end

    assign next_start = (CMPW'(w_reg) + CMPW'(1)) << WS;
    assign scan_last  = (next_start >= CMPW'(cnt_reg)) || (w_reg == WA_W'(NW - 1));

    assign idx_word = WA_W'(IX_W'(idx_reg) >> WS);
    assign idx_bit  = WS'(IX_W'(idx_reg));

    // Null address and addresses below the base are invalid.
    assign addr_bad = (faddr_reg == '0) || (faddr_reg < cfg_base_reg);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next  = state_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = w_reg;
        mem_wr_data = '0;
        mem_rd_addr = w_reg;
        div_start   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_wr_en = 1'b1;
                if (w_reg == WA_W'(NW - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_cmd == fra_pkg::CMD_FREE) ? S_FMUL : S_ARD;
                end
            end
            S_ARD: begin
                state_next = S_ACHK;
            end
            S_ACHK: begin
                if (found) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data | (WW'(1) << found_bit);
                    state_next  = S_AMUL;
                end else if (scan_last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_ARD;
                end
            end
            S_AMUL: begin
                state_next = S_AADDR;
            end
            S_AADDR: begin
                state_next = S_OUT;
            end
            S_FMUL: begin
                state_next = addr_bad ? S_OUT : S_FRANGE;
            end
            S_FRANGE: begin
                if (off_reg >= AW'(prod_reg)) begin
                    state_next = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    state_next = div_rem_zero ? S_FRD : S_OUT;
                end
            end
            S_FRD: begin
                mem_rd_addr = idx_word;
                state_next  = S_FWR;
            end
            S_FWR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_word;
                mem_wr_data = mem_rd_data & ~(WW'(1) << idx_bit);
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            w_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // advance the word pointer through the clearing pass and the scan
            if (state_reg == S_CLEAR && w_reg != WA_W'(NW - 1)) begin
                w_reg <= w_reg + WA_W'(1);
            end else if (accept) begin
                w_reg <= '0;
            end else if (state_reg == S_ACHK && !found && !scan_last) begin
                w_reg <= w_reg + WA_W'(1);
            end
            // hold the result until the transfer on the result side
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg        <= s_cmd;
            faddr_reg      <= s_free_address;
            size_reg       <= size_calc;
            cnt_reg        <= cnt_eff;
            res_status_reg <= fra_pkg::ST_OK;
            res_addr_reg   <= '0;
        end
        unique case (state_reg)
            S_ACHK: begin
                if (found) begin
                    idx_reg <= Q_W'({w_reg, found_bit});
                end else if (scan_last) begin
                    res_status_reg <= fra_pkg::ST_OOM;
                end
            end
            S_AMUL: begin
                prod_reg <= mul_out;
            end
            S_AADDR: begin
                // start address wraps modulo the address width
                res_addr_reg <= cfg_base_reg + AW'(prod_reg);
            end
            S_FMUL: begin
                prod_reg <= mul_out;
                off_reg  <= faddr_reg - cfg_base_reg;
                if (addr_bad) begin
                    res_status_reg <= fra_pkg::ST_INVALID;
                end
            end
            S_FRANGE: begin
                if (off_reg >= AW'(prod_reg)) begin
                    res_status_reg <= fra_pkg::ST_RANGE;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    idx_reg <= div_quot;
                    if (!div_rem_zero) begin
                        res_status_reg <= fra_pkg::ST_INVALID;
                    end
                end
            end
            default: ;
        endcase
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= (cmd_reg == fra_pkg::CMD_ALLOC) ? res_addr_reg : '0;
        end
    end

    // ---------------------------------------------------------------
    // Busy-bit memory and divider
    // ---------------------------------------------------------------
    fra_busy_mem #(
        .DEPTH (NW),
        .AW    (WA_W)
    ) u_busy_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fra_divider #(
        .Q_W    (Q_W),
        .SIZE_W (SIZE_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (off_reg),
        .divisor  (size_reg),
        .done     (div_done),
        .rem_zero (div_rem_zero),
        .quot     (div_quot)
    );

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_alloc_address = m_addr_reg;

`ifndef SYNTH
    // Reset starts the clearing pass: no command is taken right after it.
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("command taken during busy-bit clearing");

    // One command at a time: after a transfer in, input stays closed.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second command taken while one is in flight");

    // A failed command never carries an address.
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != fra_pkg::ST_OK) |-> (m_alloc_address == '0))
        else $error("address returned with a failing status");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_FDIV))
        else $error("divider finished outside the free sequence");
`endif

endmodule

/* design/fra_busy_mem.sv */
// Busy-bit store: one bit per region, packed in words of fra_pkg::WORD_W.
// One write port and one registered read port. Depends on fra_pkg.
module fra_busy_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [fra_pkg::WORD_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [fra_pkg::WORD_W-1:0]  rd_data
);

    logic [fra_pkg::WORD_W-1:0] mem_reg [DEPTH];
    logic [fra_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/fra_divider.sv */
// Restoring divider: one compare and subtract per cycle, Q_W quotient bits.
// The caller guarantees the quotient fits in Q_W bits. Depends on fra_pkg.
module fra_divider #(
    parameter int Q_W    = 6,
    parameter int SIZE_W = 30
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fra_pkg::ADDR_W-1:0]  dividend,
    input  logic [SIZE_W-1:0]           divisor,
    output logic                        done,
    output logic                        rem_zero,
    output logic [Q_W-1:0]              quot
);

    localparam int AW   = fra_pkg::ADDR_W;
    localparam int D_W  = SIZE_W + Q_W - 1;
    localparam int SC_W = $clog2(Q_W + 1);

    logic [AW-1:0]   rem_reg;
    logic [D_W-1:0]  div_reg;
    logic [Q_W-1:0]  quot_reg;
    logic [SC_W-1:0] step_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [AW-1:0]   div_ext;
    logic            take;

    assign div_ext = AW'(div_reg);
    assign take    = (rem_reg >= div_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SC_W'(Q_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - SC_W'(1);
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            div_reg  <= D_W'(divisor) << (Q_W - 1);
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= rem_reg - div_ext;
            end
            div_reg  <= div_reg >> 1;
            quot_reg <= (quot_reg << 1) | Q_W'(take);
        end
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);
    assign quot     = quot_reg;

endmodule

/* bench/fixed_region_allocator_unit_tb.sv */
// Self-checking bench for fixed_region_allocator_unit: directed table, then random phases.
// Predicts each reply from a shadow of the busy bits and registers.
// Depends on fra_pkg and the allocator RTL only.
module fixed_region_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fra_pkg::*;

    localparam int MAX_REGIONS     = 64;
    localparam int PAGE_BYTES      = 4096;
    localparam int TOTAL_ITEMS     = 1700;
    // Longest command path is a free; leave some margin.
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    // One row of the directed table: a command (optionally with a hand-written
    // reply) or a full register setting.
    typedef struct {
        row_kind_t          kind;
        cmd_t               op;
        logic [ADDR_W-1:0]  addr;
        bit                 typed;
        status_t            exp_status;
        logic [ADDR_W-1:0]  exp_addr;
        logic [ADDR_W-1:0]  cfg_base;
        logic [PAGES_W-1:0] cfg_pages;
        logic [COUNT_W-1:0] cfg_count;
    } stim_row_t;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } region_reply_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [ADDR_W-1:0]     cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [ADDR_W-1:0]     s_free_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [ADDR_W-1:0]     m_alloc_address;

    // Shadow of the block: busy bits and the three registers.
    bit   [MAX_REGIONS-1:0] shadow_busy;
    logic [ADDR_W-1:0]      shadow_base;
    logic [PAGES_W-1:0]     shadow_pages;
    logic [COUNT_W-1:0]     shadow_count;

    region_reply_t expected_replies [$];
    stim_row_t     directed_rows [$];

    int  mismatch_count;
    int  items_sent;
    int  allocs_sent;
    int  settings_written;
    int  status_tally [4];
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_off_request;

    fixed_region_allocator_unit #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_free_address  (s_free_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_alloc_address (m_alloc_address)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Region size in bytes; zero pages act as one, more than the maximum clamp.
    function automatic logic [63:0] region_bytes();
        logic [63:0] pages;
        pages = 64'(shadow_pages);
        if (pages == 0) pages = 1;
        if (pages > PAGES_MAX) pages = PAGES_MAX;
        return pages * PAGE_BYTES;
    endfunction

    // Number of regions consulted; a count above the pool size clamps.
    function automatic int unsigned usable_regions();
        return (shadow_count > MAX_REGIONS) ? MAX_REGIONS : int'(shadow_count);
    endfunction

    // Apply one command to the shadow and return the reply it must produce.
    function automatic void predict_region_op(input cmd_t op, input logic [ADDR_W-1:0] addr,
                                              output status_t st,
                                              output logic [ADDR_W-1:0] ret);
        logic [63:0] size;
        logic [63:0] off;
        logic [63:0] idx;
        int unsigned limit;
        bit          taken;
        size  = region_bytes();
        limit = usable_regions();
        st    = ST_OK;
        ret   = '0;
        taken = 1'b0;
        if (op == CMD_ALLOC) begin
            st = ST_OOM;
            // First fit: lowest free index below the count; start address wraps at 48 bits.
            for (int i = 0; i < int'(limit); i++) begin
                if (!taken && !shadow_busy[i]) begin
                    taken          = 1'b1;
                    shadow_busy[i] = 1'b1;
                    ret            = 48'(64'(shadow_base) + 64'(i) * size);
                    st             = ST_OK;
                end
            end
        end else if (addr == '0 || addr < shadow_base) begin
            st = ST_INVALID;
        end else begin
            off = 64'(addr - shadow_base);
            idx = off / size;
            if (idx >= 64'(limit)) begin
                st = ST_RANGE;
            end else if (off % size != 0) begin
                st = ST_INVALID;
            end else begin
                // Freeing a region that is already free is fine and changes nothing.
                shadow_busy[idx[5:0]] = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [ADDR_W-1:0] random_addr48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic stim_row_t cmd_row(input cmd_t op, input logic [ADDR_W-1:0] addr);
        stim_row_t r;
        r.kind  = ROW_CMD;
        r.op    = op;
        r.addr  = addr;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t known_row(input cmd_t op, input logic [ADDR_W-1:0] addr,
                                            input status_t st, input logic [ADDR_W-1:0] ret);
        stim_row_t r;
        r            = cmd_row(op, addr);
        r.typed      = 1'b1;
        r.exp_status = st;
        r.exp_addr   = ret;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [ADDR_W-1:0] base,
                                          input logic [PAGES_W-1:0] pages,
                                          input logic [COUNT_W-1:0] count);
        stim_row_t r;
        r.kind      = ROW_CFG;
        r.cfg_base  = base;
        r.cfg_pages = pages;
        r.cfg_count = count;
        return r;
    endfunction

    // Offer one command, hold it until the transfer, then record the reply it owes.
    // Call at a rising edge; a zero gap keeps valid high straight into the next command.
    task automatic send_cmd(input cmd_t op, input logic [ADDR_W-1:0] addr, input bit typed,
                            input status_t typed_status, input logic [ADDR_W-1:0] typed_addr);
        int            gap;
        region_reply_t reply;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_cmd          <= op;
        s_free_address <= addr;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_region_op(op, addr, reply.status, reply.addr);
        if (typed) begin
            reply.status = typed_status;
            reply.addr   = typed_addr;
        end
        expected_replies.push_back(reply);
        items_sent++;
        if (op == CMD_ALLOC) allocs_sent++;
    endtask

    // Drop valid, wait for every owed reply, then let the pipeline go quiet.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; only call while idle.
    task automatic write_config(input logic [ADDR_W-1:0] base,
                                input logic [PAGES_W-1:0] pages,
                                input logic [COUNT_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_BASE;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_index   <= CFG_PAGES;
        cfg_wr_data <= 48'(pages);
        @(posedge aclk);
        cfg_index   <= CFG_COUNT;
        cfg_wr_data <= 48'(count);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        // Busy bits survive a register change on purpose.
        shadow_base  = base;
        shadow_pages = pages;
        shadow_count = count;
        settings_written++;
    endtask

    // ------------------------------------------------------------------
    // Reply checker: compare each transfer on the result side with the oldest
    // expectation; report the first few mismatches in full, count the rest.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        region_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (!$isunknown(m_status)) status_tally[m_status]++;
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected reply: status %0d addr %h",
                             $time, m_status, m_alloc_address);
            end else begin
                want = expected_replies.pop_front();
                if (m_status !== want.status || m_alloc_address !== want.addr) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] reply mismatch: expected status %0d addr %h, got status %0d addr %h",
                                 $time, want.status, want.addr, m_status, m_alloc_address);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready: random stalls, plus one long hold-off on request so
    // the block fills and pushes back on the command side.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge aclk);
            end else begin
                gap = rx_idle_en ? pick_gap() : 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(posedge aclk);
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned        limit;
        int unsigned        start;
        int unsigned        idx;
        int unsigned        sel;
        int unsigned        n_items;
        int unsigned        alloc_pct;
        int                 phase;
        logic [63:0]        size;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  base_v;
        logic [PAGES_W-1:0] pages_v;
        logic [COUNT_W-1:0] count_v;
        cmd_t               op;

        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_BASE;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_cmd            = CMD_ALLOC;
        s_free_address   = '0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        hold_off_request = 1'b0;
        mismatch_count   = 0;
        items_sent       = 0;
        allocs_sent      = 0;
        settings_written = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        shadow_busy      = '0;
        shadow_base      = '0;
        shadow_pages     = 17'd1;
        shadow_count     = 7'd1;

        // Directed table. Hand-written replies only where they are obvious;
        // everything else goes through the shadow model.
        // Reset setting: one 4 KiB region at address zero.
        directed_rows.push_back(known_row(CMD_ALLOC, '0, ST_OK, '0));
        directed_rows.push_back(known_row(CMD_ALLOC, '0, ST_OOM, '0));
        directed_rows.push_back(known_row(CMD_FREE, '0, ST_INVALID, '0));
        directed_rows.push_back(known_row(CMD_FREE, 48'h1000, ST_RANGE, '0));
        directed_rows.push_back(known_row(CMD_FREE, 48'h800, ST_INVALID, '0));
        directed_rows.push_back(known_row(CMD_FREE, 48'hFFFF_FFFF_FFFF, ST_RANGE, '0));
        // Zero pages and zero regions.
        directed_rows.push_back(cfg_row(48'h1_0000, 17'd0, 7'd0));
        directed_rows.push_back(known_row(CMD_ALLOC, '0, ST_OOM, '0));
        directed_rows.push_back(known_row(CMD_FREE, 48'h1_0000, ST_RANGE, '0));
        directed_rows.push_back(known_row(CMD_FREE, 48'hFFFF, ST_INVALID, '0));
        // Count above the pool size; region 0 is still busy from before.
        directed_rows.push_back(cfg_row(48'h1_0000, 17'd2, 7'd127));
        directed_rows.push_back(cmd_row(CMD_ALLOC, '0));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h1_0000));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h1_0000));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h1_2001));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h9_0000));
        directed_rows.push_back(cmd_row(CMD_ALLOC, '0));
        // Page count beyond the maximum near the top of the space: region starts wrap.
        directed_rows.push_back(cfg_row(48'hFFFF_F000_0000, 17'h1_FFFF, 7'd64));
        directed_rows.push_back(cmd_row(CMD_ALLOC, '0));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h1000_0000));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'hFFFF_FFFF_FFFF));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'hFFFF_F000_0000));
        // Highest base, largest legal page count, single region.
        directed_rows.push_back(cfg_row(48'hFFFF_FFFF_FFFF, 17'd65536, 7'd1));
        directed_rows.push_back(cmd_row(CMD_ALLOC, '0));
        directed_rows.push_back(known_row(CMD_ALLOC, '0, ST_OOM, '0));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'hFFFF_FFFF_FFFF));
        // Base zero: region 0 sits at address zero but can't be freed by address.
        directed_rows.push_back(cfg_row('0, 17'd1, 7'd64));
        directed_rows.push_back(known_row(CMD_FREE, '0, ST_INVALID, '0));
        directed_rows.push_back(cmd_row(CMD_ALLOC, '0));
        directed_rows.push_back(cmd_row(CMD_FREE, 48'h1000));

        // Hold reset, then let the clearing pass finish.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (10) @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle_idle();
                write_config(directed_rows[r].cfg_base, directed_rows[r].cfg_pages,
                             directed_rows[r].cfg_count);
            end else begin
                send_cmd(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].typed,
                         directed_rows[r].exp_status, directed_rows[r].exp_addr);
            end
        end

        // Random phases: each picks a register setting, an alloc/free mix and
        // whether either side idles, then runs a burst of commands.
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            phase++;
            case ($urandom_range(0, 5))
                0:       base_v = '0;
                1:       base_v = 48'($urandom_range(1, 1 << 20));
                2:       base_v = {16'hFFFF, $urandom()};
                3:       base_v = '1;
                default: base_v = random_addr48();
            endcase
            case ($urandom_range(0, 9))
                6:       pages_v = 17'd65536;
                7:       pages_v = '1;
                8:       pages_v = 17'($urandom_range(0, 131071));
                9:       pages_v = 17'($urandom_range(65537, 131071));
                default: pages_v = 17'($urandom_range(0, 4));
            endcase
            // Mostly small pools so they fill up and run dry often.
            case ($urandom_range(0, 9))
                6:       count_v = 7'd64;
                7:       count_v = 7'd0;
                8:       count_v = 7'($urandom_range(65, 127));
                9:       count_v = 7'($urandom_range(0, 127));
                default: count_v = 7'($urandom_range(1, 8));
            endcase
            settle_idle();
            write_config(base_v, pages_v, count_v);

            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            alloc_pct  = $urandom_range(30, 75);
            n_items    = $urandom_range(40, 150);

            for (int k = 0; k < int'(n_items); k++) begin
                // Stall the result side for a long stretch while commands keep coming.
                if (phase == 3 && k == 5) hold_off_request = 1'b1;
                // Once, pause the command side until every reply is back.
                if (phase == 2 && k == int'(n_items / 2)) settle_idle();

                limit = usable_regions();
                size  = region_bytes();
                addr  = random_addr48();
                op    = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
                if (op == CMD_FREE) begin
                    sel = $urandom_range(0, 19);
                    if (sel < 12 && limit > 0) begin
                        // Mostly aim at a busy region so frees actually release something.
                        start = $urandom_range(0, limit - 1);
                        idx   = start;
                        if (sel < 10) begin
                            for (int j = int'(limit) - 1; j >= 0; j--)
                                if (shadow_busy[(start + j) % limit]) idx = (start + j) % limit;
                        end
                        addr = 48'(64'(shadow_base) + 64'(idx) * size);
                    end else if (sel == 12) begin
                        addr = 48'(64'(shadow_base) + 64'(limit + $urandom_range(0, 7)) * size);
                    end else if (sel < 15) begin
                        addr = 48'(64'(shadow_base) + 64'($urandom_range(0, limit)) * size
                                   + 64'($urandom_range(1, 32'(size - 1))));
                    end else if (sel == 15) begin
                        addr = '0;
                    end else if (sel == 16 && shadow_base != '0) begin
                        addr = 48'(64'(random_addr48()) % 64'(shadow_base));
                    end
                end
                send_cmd(op, addr, 1'b0, ST_OK, '0);
            end
        end

        settle_idle();

        $display("Covered %0d commands (%0d alloc, %0d free) over %0d register settings.",
                 items_sent, allocs_sent, items_sent - allocs_sent, settings_written);
        $display("Replies seen: ok %0d, out of memory %0d, invalid %0d, out of range %0d.",
                 status_tally[ST_OK], status_tally[ST_OOM], status_tally[ST_INVALID],
                 status_tally[ST_RANGE]);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
